/* rtl/bssc_pkg.sv */
`timescale 1ns / 1ps

package bssc_pkg;

    localparam int MAX_VALUE = 128;
    localparam int VAL_W     = $clog2(MAX_VALUE + 1);
    localparam int SCORE_W   = 8;
    localparam int CMP_W     = (VAL_W > SCORE_W) ? VAL_W : SCORE_W;
    localparam int WAYS_W    = 30;
    localparam int SUM3_W    = WAYS_W + 2;
    localparam int CNT_W     = $clog2(MAX_VALUE + 1);
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [WAYS_W-1:0]  WAYS_MOD        = WAYS_W'(1000000007);
    localparam logic [SCORE_W-1:0] MAX_VALUE_RESET = SCORE_W'(128);

    // word index taken from paddr[2]
    localparam logic REG_MAX_VALUE = 1'b0;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    typedef struct packed {
        logic               update;
        logic               first;
        logic [SCORE_W-1:0] score;
        logic [VAL_W-1:0]   lim;
    } cell_ctl_t;

    function automatic logic [WAYS_W-1:0] mod_add2(
        input logic [WAYS_W-1:0] a,
        input logic [WAYS_W-1:0] b
    );
        logic [WAYS_W:0] s;
        logic [WAYS_W:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, WAYS_MOD};
        return (s >= {1'b0, WAYS_MOD}) ? d[WAYS_W-1:0] : s[WAYS_W-1:0];
    endfunction

    // inputs are below the modulus, so the sum stays below three times it
    function automatic logic [WAYS_W-1:0] mod_add3(
        input logic [WAYS_W-1:0] a,
        input logic [WAYS_W-1:0] b,
        input logic [WAYS_W-1:0] c
    );
        logic [SUM3_W-1:0] s;
        logic [SUM3_W-1:0] p1;
        logic [SUM3_W-1:0] p2;
        logic [SUM3_W-1:0] r;
        p1 = SUM3_W'(WAYS_MOD);
        p2 = p1 + p1;
        s  = SUM3_W'(a) + SUM3_W'(b) + SUM3_W'(c);
        if (s >= p2)
        begin
            r = s - p2;
        end
        else if (s >= p1)
        begin
            r = s - p1;
        end
        else
        begin
            r = s;
        end
        return r[WAYS_W-1:0];
    endfunction

endpackage

/* rtl/bssc_cell.sv */
`timescale 1ns / 1ps

module bssc_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [bssc_pkg::VAL_W-1:0]  idx,
    input  bssc_pkg::cell_ctl_t         ctl,
    input  logic [bssc_pkg::WAYS_W-1:0] left_count,
    input  logic [bssc_pkg::WAYS_W-1:0] right_count,
    output logic [bssc_pkg::WAYS_W-1:0] count_out,
    input  logic [bssc_pkg::WAYS_W-1:0] sum_in,
    output logic [bssc_pkg::WAYS_W-1:0] sum_out
);

    logic [bssc_pkg::WAYS_W-1:0] count_reg;
    logic [bssc_pkg::WAYS_W-1:0] count_next;
    logic [bssc_pkg::WAYS_W-1:0] sum_reg;
    logic [bssc_pkg::WAYS_W-1:0] sum_next;
    logic                        in_range;
    logic                        match;
    logic                        allowed;

    assign in_range = (idx <= ctl.lim);
    assign match    = (ctl.score == '0)
                   || (bssc_pkg::CMP_W'(ctl.score) == bssc_pkg::CMP_W'(idx));
    assign allowed  = in_range && match;

    always_comb
    begin
        count_next = count_reg;
        if (ctl.update)
        begin
            if (!allowed)
            begin
                count_next = '0;
            end
            else if (ctl.first)
            begin
                count_next = bssc_pkg::WAYS_W'(1);
            end
            else
            begin
                count_next = bssc_pkg::mod_add3(left_count, count_reg, right_count);
            end
        end
    end

    // running total ripples one cell per cycle toward the end of the row
    assign sum_next = bssc_pkg::mod_add2(sum_in, count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // counts above the limit read as zero to the neighbors
    assign count_out = in_range ? count_reg : '0;
    assign sum_out   = sum_reg;

    a_count_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < bssc_pkg::WAYS_MOD)
        else $error("cell count not reduced");

    a_sum_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg < bssc_pkg::WAYS_MOD)
        else $error("cell running sum not reduced");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.update |=> $stable(count_reg))
        else $error("cell count changed without an update");

endmodule

/* rtl/bounded_step_sequence_counter.sv */
`timescale 1ns / 1ps

// Counts, modulo 1000000007, the sequences with values in 1..max_value whose
// neighbors differ by at most one and that match every fixed element (score 0
// marks a free position, first = 1 starts a new sequence). A row of 128 cells
// holds one count per value; all cells update in the cycle an element is
// transferred in. The total then ripples through the row as a running sum, one
// cell per cycle, and a down counter waits for it to reach the last cell before
// the ways result is registered. The block takes no new element until it is back
// in idle, and it leaves busy only once no previous result is held by out_stall.
// A new element may be transferred in while the previous result still waits on
// the output. max_value is at byte address 0; the user must write it only while
// idle, and the block itself does not enforce this.

module bounded_step_sequence_counter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bssc_pkg::ADDR_W-1:0]  paddr,
    input  logic [bssc_pkg::DATA_W-1:0]  pwdata,
    output logic [bssc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bssc_pkg::SCORE_W-1:0] score,
    input  logic                         first,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bssc_pkg::WAYS_W-1:0]  ways
);

    localparam int N = bssc_pkg::MAX_VALUE;

    bssc_pkg::state_t               state_reg;
    bssc_pkg::state_t               state_next;
    logic [bssc_pkg::CNT_W-1:0]     cnt_reg;
    logic [bssc_pkg::CNT_W-1:0]     cnt_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [bssc_pkg::WAYS_W-1:0]    ways_reg;
    logic [bssc_pkg::WAYS_W-1:0]    ways_next;
    logic [bssc_pkg::SCORE_W-1:0]   max_value_reg;
    logic [bssc_pkg::SCORE_W-1:0]   max_value_next;

    logic                           accept_in;
    logic                           take_out;
    logic                           done;
    logic                           cfg_wr;
    logic [bssc_pkg::CMP_W-1:0]     max_ext;
    logic [bssc_pkg::CMP_W-1:0]     lim_ext;
    bssc_pkg::cell_ctl_t            ctl;

    logic [bssc_pkg::WAYS_W-1:0]    vis [0:N+1];
    logic [bssc_pkg::WAYS_W-1:0]    sums [0:N];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        max_value_next = max_value_reg;
        if (cfg_wr && (paddr[2] == bssc_pkg::REG_MAX_VALUE))
        begin
            max_value_next = pwdata[bssc_pkg::SCORE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == bssc_pkg::REG_MAX_VALUE)
        begin
            prdata = bssc_pkg::DATA_W'(max_value_reg);
        end
    end

    // limit saturates at the row length
    assign max_ext = bssc_pkg::CMP_W'(max_value_reg);
    assign lim_ext = (max_ext > bssc_pkg::CMP_W'(N)) ? bssc_pkg::CMP_W'(N) : max_ext;

    assign accept_in = in_valid && !in_stall;
    assign take_out  = out_valid_reg && !out_stall;
    assign done      = (state_reg == bssc_pkg::ST_BUSY) && (cnt_reg == '0)
                    && (!out_valid_reg || !out_stall);

    assign ctl.update = accept_in;
    assign ctl.first  = first;
    assign ctl.score  = score;
    assign ctl.lim    = lim_ext[bssc_pkg::VAL_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bssc_pkg::ST_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = bssc_pkg::ST_BUSY;
                end
            end
            bssc_pkg::ST_BUSY:
            begin
                if (done)
                begin
                    state_next = bssc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bssc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        in_stall = 1'b0;
        unique case (state_reg)
            bssc_pkg::ST_IDLE: in_stall = 1'b0;
            bssc_pkg::ST_BUSY: in_stall = 1'b1;
            default:           in_stall = 1'b1;
        endcase
    end

    // wait for the running sum to reach the last cell
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept_in)
        begin
            cnt_next = bssc_pkg::CNT_W'(N);
        end
        else if ((state_reg == bssc_pkg::ST_BUSY) && (cnt_reg != '0))
        begin
            cnt_next = cnt_reg - bssc_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        ways_next      = ways_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
            ways_next      = sums[N];
        end
        else if (take_out)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bssc_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            max_value_reg <= bssc_pkg::MAX_VALUE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            max_value_reg <= max_value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ways_reg <= ways_next;
    end

    assign out_valid = out_valid_reg;
    assign ways      = ways_reg;

    // row of cells, guard slots at both ends read as zero
    assign vis[0]   = '0;
    assign vis[N+1] = '0;
    assign sums[0]  = '0;

    for (genvar k = 1; k <= N; k++)
    begin : g_cell
        bssc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .idx         (bssc_pkg::VAL_W'(k)),
            .ctl         (ctl),
            .left_count  (vis[k-1]),
            .right_count (vis[k+1]),
            .count_out   (vis[k]),
            .sum_in      (sums[k-1]),
            .sum_out     (sums[k])
        );
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> (state_reg == bssc_pkg::ST_BUSY) && (cnt_reg == bssc_pkg::CNT_W'(N)))
        else $error("transfer in did not start the sum sweep");

    a_result_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past((state_reg == bssc_pkg::ST_BUSY) && (cnt_reg == '0)))
        else $error("result raised before the sweep finished");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (ways_reg < bssc_pkg::WAYS_MOD))
        else $error("result not reduced");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(ways_reg))
        else $error("pending result overwritten");

endmodule

/* tb/sv/tb_bounded_step_sequence_counter.sv */
`timescale 1ns / 1ps

module tb_bounded_step_sequence_counter;

    localparam int                          HALF_PERIOD  = 6;
    localparam int                          IDLE_PCT     = 14;
    localparam int                          SETTLE       = 140;
    localparam int                          STUCK_LIMIT  = 6000;
    localparam int                          PHASES       = 10;
    localparam int                          PHASE_ITEMS  = 65;
    localparam longint unsigned             P            = 1000000007;
    localparam logic [bssc_pkg::ADDR_W-1:0] MAX_VAL_ADDR = {bssc_pkg::REG_MAX_VALUE, 2'b00};

    typedef struct packed {
        logic [bssc_pkg::SCORE_W-1:0] score;
        logic                         first;
    } element_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           psel      = 1'b0;
    logic                           penable   = 1'b0;
    logic                           pwrite    = 1'b0;
    logic [bssc_pkg::ADDR_W-1:0]    paddr     = '0;
    logic [bssc_pkg::DATA_W-1:0]    pwdata    = '0;
    logic [bssc_pkg::DATA_W-1:0]    prdata;
    logic                           pready;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    logic [bssc_pkg::SCORE_W-1:0]   score     = '0;
    logic                           first     = 1'b0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [bssc_pkg::WAYS_W-1:0]    ways;

    element_t                       pending[$];
    logic [bssc_pkg::WAYS_W-1:0]    ways_expected[$];
    logic [bssc_pkg::WAYS_W-1:0]    ends_at[0:bssc_pkg::MAX_VALUE+1];
    logic [bssc_pkg::SCORE_W-1:0]   max_value_reg = bssc_pkg::MAX_VALUE_RESET;
    element_t                       head_item;
    logic                           quiet   = 1'b0;
    int                             errors  = 0;
    int                             stuck   = 0;

    bounded_step_sequence_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .score     (score),
        .first     (first),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ways      (ways)
    );

    always #HALF_PERIOD clk = ~clk;

    // advances the per-value counts by one element and returns the total
    function automatic logic [bssc_pkg::WAYS_W-1:0] count_ways(
        input logic [bssc_pkg::SCORE_W-1:0] s,
        input logic                         f
    );
        logic [bssc_pkg::WAYS_W-1:0] fresh[0:bssc_pkg::MAX_VALUE+1];
        longint unsigned             acc;
        longint unsigned             total;
        int                          lim;
        lim = (max_value_reg > bssc_pkg::MAX_VALUE) ? bssc_pkg::MAX_VALUE
                                                    : int'(max_value_reg);
        total = 0;
        for (int v = 0; v <= bssc_pkg::MAX_VALUE + 1; v++)
        begin
            fresh[v] = '0;
            if (v >= 1 && v <= lim && (s == 0 || s == v))
            begin
                if (f)
                begin
                    fresh[v] = bssc_pkg::WAYS_W'(1);
                end
                else
                begin
                    acc = 64'(ends_at[v]);
                    if (v - 1 >= 1)
                    begin
                        acc += 64'(ends_at[v-1]);
                    end
                    if (v + 1 <= lim)
                    begin
                        acc += 64'(ends_at[v+1]);
                    end
                    fresh[v] = bssc_pkg::WAYS_W'(acc % P);
                end
            end
        end
        for (int v = 0; v <= bssc_pkg::MAX_VALUE + 1; v++)
        begin
            ends_at[v] = fresh[v];
            total += 64'(fresh[v]);
        end
        return bssc_pkg::WAYS_W'(total % P);
    endfunction

    // input driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                ways_expected = {ways_expected, count_ways(score, first)};
            end
            if (!in_valid || !in_stall)
            begin
                if (pending.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    head_item = pending.pop_front();
                    score    <= head_item.score;
                    first    <= head_item.first;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (ways_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, ways expected none actual %0d",
                             $time, ways);
                    errors++;
                end
                else if (ways !== ways_expected[0])
                begin
                    $display("%0t: ways mismatch, expected %0d actual %0d",
                             $time, ways_expected[0], ways);
                    errors++;
                    void'(ways_expected.pop_front());
                end
                else
                begin
                    void'(ways_expected.pop_front());
                end
            end
            out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stuck <= 0;
        end
        else
        begin
            stuck <= stuck + 1;
        end
        if (stuck >= STUCK_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic apb_write(input logic [bssc_pkg::SCORE_W-1:0] value);
        logic [bssc_pkg::DATA_W-1:0] word;
        word      = $urandom();
        word[7:0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_VAL_ADDR;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        max_value_reg = value;
    endtask

    task automatic apb_read_check();
        logic [bssc_pkg::DATA_W-1:0] want;
        want = bssc_pkg::DATA_W'(max_value_reg);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= MAX_VAL_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            $display("%0t: max_value readback mismatch, expected %0d actual %0d",
                     $time, want, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_element(input logic [bssc_pkg::SCORE_W-1:0] s, input logic f);
        element_t e;
        e.score = s;
        e.first = f;
        pending = {pending, e};
    endtask

    // wait until every element is in and every result is out, then let the row settle
    task automatic drain();
        @(negedge clk);
        while (pending.size() != 0 || in_valid || ways_expected.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(input logic [bssc_pkg::SCORE_W-1:0] value);
        apb_write(value);
        apb_read_check();
        @(negedge clk);
    endtask

    // one walk of random length, mostly free positions with a few pinned values
    task automatic add_walk(input int len, input logic fresh_start);
        int lim;
        lim = (max_value_reg == 0) ? bssc_pkg::MAX_VALUE :
              (max_value_reg > bssc_pkg::MAX_VALUE) ? bssc_pkg::MAX_VALUE
                                                    : int'(max_value_reg);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                push_element(bssc_pkg::SCORE_W'($urandom_range(1, lim)),
                             fresh_start && i == 0);
            end
            else
            begin
                push_element('0, fresh_start && i == 0);
            end
        end
    endtask

    initial
    begin
        int          phase_count;
        int          walk_len;
        logic [7:0]  reg_pick;

        for (int v = 0; v <= bssc_pkg::MAX_VALUE + 1; v++)
        begin
            ends_at[v] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        apb_read_check();
        @(negedge clk);

        // nothing started yet, then full range with edge values
        push_element(8'd0, 1'b0);
        push_element(8'd5, 1'b0);
        push_element(8'd0, 1'b1);
        push_element(8'd0, 1'b0);
        push_element(8'd128, 1'b0);
        push_element(8'd127, 1'b0);
        push_element(8'd0, 1'b0);
        push_element(8'd1, 1'b1);
        push_element(8'd2, 1'b0);
        push_element(8'd0, 1'b0);
        drain();

        // limit lowered mid-sequence, then a pinned value beyond it
        configure(8'd5);
        push_element(8'd0, 1'b0);
        push_element(8'd5, 1'b0);
        push_element(8'd200, 1'b0);
        push_element(8'd0, 1'b0);
        push_element(8'd6, 1'b1);
        drain();

        // zero register allows nothing
        configure(8'd0);
        push_element(8'd0, 1'b1);
        push_element(8'd1, 1'b0);
        drain();

        // register above the row size saturates
        configure(8'd255);
        push_element(8'd0, 1'b1);
        push_element(8'd128, 1'b0);
        push_element(8'd0, 1'b0);
        push_element(8'd255, 1'b1);
        push_element(8'd0, 1'b0);
        drain();

        configure(8'd1);
        push_element(8'd0, 1'b1);
        push_element(8'd1, 1'b0);
        push_element(8'd0, 1'b0);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(0, 9))
                0:       reg_pick = 8'd128;
                1:       reg_pick = 8'd1;
                2:       reg_pick = 8'd2;
                3:       reg_pick = 8'd127;
                4:       reg_pick = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
                5:       reg_pick = 8'($urandom_range(129, 255));
                default: reg_pick = 8'($urandom_range(1, 128));
            endcase
            if (ph == 0)
            begin
                reg_pick = 8'd128;
            end
            configure(reg_pick);
            quiet = (ph == PHASES / 2);
            phase_count = 0;
            while (phase_count < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    push_element(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    phase_count++;
                end
                else
                begin
                    walk_len = $urandom_range(1, 45);
                    // some walks carry on from whatever the row holds
                    add_walk(walk_len, $urandom_range(0, 4) != 0);
                    phase_count += walk_len;
                end
            end
            drain();
            quiet = 1'b0;
        end

        if (errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
